FILE: rtl/pqe_pkg.sv
package pqe_pkg;

  // fixed-point layout
  localparam int PRED_FRAC   = 24;
  localparam int COEFF_SHIFT = 8;
  localparam int DW          = 52;   // working width of predictions and offsets
  localparam int TW          = 72;   // width of the saturation thresholds
  localparam int RW          = 48;   // reconstruction / line entry width
  localparam int CW          = 10;   // coefficient width
  localparam int SHW         = 6;    // rounding shift amount, 8 .. 39

  // configuration register widths
  localparam int TPW        = 5;
  localparam int AXW        = 2;
  localparam int LENW       = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_POWER   = 3'd0,
    REG_AXIS_COUNT   = 3'd1,
    REG_ROW_LENGTH   = 3'd2,
    REG_COEFF_ALONG  = 3'd3,
    REG_COEFF_ACROSS = 3'd4
  } cfg_reg_t;

  // per-word flags from the sequencer into the datapath
  typedef struct packed {
    logic valid;
    logic use_across;
    logic pw_clear;
  } issue_t;

  typedef struct packed {
    logic [31:0] code;
    logic        sat;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } oq_stat_t;

endpackage

FILE: rtl/pqe_ctrl.sv
module pqe_ctrl #(
  parameter int MAX_ROW = 1024,
  localparam int POS_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_start_req,
  output logic                              in_ready,
  input  logic [pqe_pkg::AXW-1:0]           axis_count,
  input  logic [pqe_pkg::LENW-1:0]          row_length,
  input  logic signed [pqe_pkg::CW-1:0]     coeff_across,
  input  logic                              pop,
  output pqe_pkg::issue_t                   issue,
  output logic [POS_W-1:0]                  issue_pos
);
  import pqe_pkg::*;

  localparam int CNT_W = $clog2(MAX_ROW + 1);
  localparam int CMPW  = ((CNT_W > LENW) ? CNT_W : LENW) + 1;

  logic [POS_W-1:0]    col_pos_r, col_pos_nxt, last_pos_r, pos_cur;
  logic                past_first_r, past_first_nxt, pf_cur;
  logic                wrap_clear_r, wrap_clear_nxt;
  logic [4:0]          busy_r;
  logic [OQ_CNT_W-1:0] occ_r, occ_nxt;
  logic [CMPW-1:0]     len_eff, pos_inc;
  logic                two_axes, accept, wrap, same_entry_hold;

  assign two_axes = axis_count[1];

  // effective row length: zero acts as one, clipped to the line buffer
  always_comb begin
    if (row_length == '0) begin
      len_eff = CMPW'(1);
    end else if (CMPW'(row_length) > CMPW'(MAX_ROW)) begin
      len_eff = CMPW'(MAX_ROW);
    end else begin
      len_eff = CMPW'(row_length);
    end
  end

  // position of the incoming word and the row sequence after it
  always_comb begin
    pos_cur        = in_start_req ? '0 : col_pos_r;
    pf_cur         = in_start_req ? 1'b0 : past_first_r;
    pos_inc        = CMPW'(pos_cur) + CMPW'(1);
    wrap           = (pos_inc >= len_eff);
    col_pos_nxt    = wrap ? '0 : pos_inc[POS_W-1:0];
    past_first_nxt = wrap ? 1'b1 : pf_cur;
    wrap_clear_nxt = wrap && two_axes;
  end

  // hold while the feedback loop is busy, while the previous word has not yet
  // written the same line entry, or while no result slot is left
  assign same_entry_hold = (busy_r[3] | busy_r[4]) && (pos_cur == last_pos_r);
  assign in_ready = !(|busy_r[2:0]) && !same_entry_hold &&
                    (occ_r < OQ_CNT_W'(OQ_DEPTH));
  assign accept   = in_valid && in_ready;

  assign issue.valid      = accept;
  assign issue.use_across = two_axes && pf_cur && (coeff_across != '0);
  assign issue.pw_clear   = in_start_req || wrap_clear_r;
  assign issue_pos        = pos_cur;

  // words in flight plus results waiting
  always_comb begin
    case ({accept, pop})
      2'b10:   occ_nxt = occ_r + OQ_CNT_W'(1);
      2'b01:   occ_nxt = occ_r - OQ_CNT_W'(1);
      default: occ_nxt = occ_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r    <= '0;
      past_first_r <= 1'b0;
      wrap_clear_r <= 1'b0;
      last_pos_r   <= '0;
      busy_r       <= '0;
      occ_r        <= '0;
    end else begin
      busy_r <= {busy_r[3:0], accept};
      occ_r  <= occ_nxt;
      if (accept) begin
        col_pos_r    <= col_pos_nxt;
        past_first_r <= past_first_nxt;
        wrap_clear_r <= wrap_clear_nxt;
        last_pos_r   <= pos_cur;
      end
    end
  end

endmodule

FILE: rtl/pqe_dpath.sv
module pqe_dpath #(
  parameter int MAX_ROW = 1024,
  parameter int FRAC_BITS = 16,
  localparam int POS_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pqe_pkg::issue_t                issue,
  input  logic [POS_W-1:0]               issue_pos,
  input  logic signed [31:0]             in_sample,
  input  logic signed [pqe_pkg::TPW-1:0] tick_power,
  input  logic signed [pqe_pkg::CW-1:0]  coeff_along,
  input  logic signed [pqe_pkg::CW-1:0]  coeff_across,
  output logic                           push,
  output pqe_pkg::result_t               push_data
);
  import pqe_pkg::*;

  localparam int XSH = PRED_FRAC - FRAC_BITS;
  localparam int PW  = RW + CW;   // coefficient product width
  localparam int EW  = 60;        // width seen by the 48-bit clamp

  function automatic logic signed [RW-1:0] clamp_rw(input logic signed [EW-1:0] v);
    logic signed [RW-1:0] r;
    if ((&v[EW-1:RW-1]) || !(|v[EW-1:RW-1])) begin
      r = v[RW-1:0];
    end else if (v[EW-1]) begin
      r = {1'b1, {(RW-1){1'b0}}};
    end else begin
      r = {1'b0, {(RW-1){1'b1}}};
    end
    return r;
  endfunction

  // step constants derived from tick_power
  logic [SHW-1:0] sh_nxt, sh_r;
  logic [DW-1:0]  half_nxt, half_r, mask_nxt, mask_r;
  logic [TW-1:0]  top_w, unit_w;
  logic [TW-1:0]  thr_pos_nxt, thr_pos_r, thr_neg_nxt, thr_neg_r;
  logic [DW-1:0]  satstep_pos_nxt, satstep_pos_r, satstep_neg_nxt, satstep_neg_r;

  always_comb begin
    sh_nxt          = SHW'(PRED_FRAC + int'(tick_power));
    half_nxt        = DW'(1) << (sh_nxt - SHW'(1));
    mask_nxt        = (DW'(1) << sh_nxt) - DW'(1);
    top_w           = TW'(1) << (7'(sh_nxt) + 7'd31);
    unit_w          = TW'(1) << sh_nxt;
    thr_pos_nxt     = top_w - TW'(half_nxt);
    thr_neg_nxt     = top_w + unit_w - TW'(half_nxt);
    satstep_pos_nxt = DW'(top_w - unit_w);
    satstep_neg_nxt = DW'(top_w);
  end

  always_ff @(posedge clk) begin
    sh_r          <= sh_nxt;
    half_r        <= half_nxt;
    mask_r        <= mask_nxt;
    thr_pos_r     <= thr_pos_nxt;
    thr_neg_r     <= thr_neg_nxt;
    satstep_pos_r <= satstep_pos_nxt;
    satstep_neg_r <= satstep_neg_nxt;
  end

  // line buffer, read at accept, written when the reconstruction is done
  logic signed [RW-1:0] row_mem [MAX_ROW];
  logic signed [RW-1:0] rd_r;
  logic signed [RW-1:0] recon_nxt;
  logic                 s5_v_r;
  logic [POS_W-1:0]     s5_pos_r;

  always_ff @(posedge clk) begin
    if (issue.valid) begin
      rd_r <= row_mem[issue_pos];
    end
    if (s5_v_r) begin
      row_mem[s5_pos_r] <= recon_nxt;
    end
  end

  // stage registers
  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r, s6_v_r;
  logic signed [DW-1:0] s1_x_r, s2_x_r;
  logic [POS_W-1:0]     s1_pos_r, s2_pos_r, s3_pos_r, s4_pos_r;
  logic                 s1_ua_r;
  logic                 s1_pwc_r, s2_pwc_r, s3_pwc_r;
  logic signed [PW-1:0] s2_xprod_r;
  logic signed [DW-1:0] s3_xa_r, s3_acr_r;
  logic signed [DW-1:0] s4_dpos_r, s4_dneg_r, s4_pred_r;
  logic                 s5_neg_r, s5_sat_r;
  logic [DW-1:0]        s5_rsum_r;
  logic signed [DW-1:0] s5_pred_r;
  logic signed [RW-1:0] s6_recon_r;
  logic [31:0]          s6_qabs_r;
  logic                 s6_neg_r, s6_sat_r;
  logic signed [PW-1:0] prod_r;

  // combinational stage results
  logic signed [DW-1:0]   x_nxt;
  logic signed [CW-1:0]   cx_op;
  logic signed [DW-1:0]   acr_nxt;
  logic signed [RW-1:0]   pw;
  logic signed [DW-1:0]   pw_w;
  logic                   neg_nxt, sat_nxt;
  logic [DW-1:0]          mag, rsum_nxt;
  logic [DW-1:0]          step;
  logic signed [DW+1:0]   recon_w;
  logic [31:0]            qabs_nxt;

  always_comb begin
    // sample to 24 fractional bits
    x_nxt = $signed({{(DW-32){in_sample[31]}}, in_sample}) <<< XSH;
    // row-above operand
    cx_op = s1_ua_r ? coeff_across : '0;
    // row-above term
    acr_nxt = DW'(s2_xprod_r >>> COEFF_SHIFT);
    // along-row term from the previous reconstruction
    pw   = s3_pwc_r ? '0 : clamp_rw(EW'(prod_r >>> COEFF_SHIFT));
    pw_w = DW'(pw);
    // magnitude, rounding and saturation test
    neg_nxt  = s4_dpos_r[DW-1];
    mag      = neg_nxt ? s4_dneg_r : s4_dpos_r;
    rsum_nxt = mag + half_r;
    sat_nxt  = neg_nxt ? ({{(TW-DW){1'b0}}, mag} >= thr_neg_r)
                       : ({{(TW-DW){1'b0}}, mag} >= thr_pos_r);
    // reconstruction and code magnitude
    if (s5_sat_r) begin
      step     = s5_neg_r ? satstep_neg_r : satstep_pos_r;
      qabs_nxt = s5_neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      step     = s5_rsum_r & ~mask_r;
      qabs_nxt = 32'(s5_rsum_r >> sh_r);
    end
    recon_w = s5_neg_r ? ((DW+2)'(s5_pred_r) - $signed({2'b00, step}))
                       : ((DW+2)'(s5_pred_r) + $signed({2'b00, step}));
    recon_nxt = clamp_rw(EW'(recon_w));
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (issue.valid) begin
      s1_x_r   <= x_nxt;
      s1_pos_r <= issue_pos;
      s1_ua_r  <= issue.use_across;
      s1_pwc_r <= issue.pw_clear;
    end
    s2_xprod_r <= rd_r * cx_op;
    s2_x_r     <= s1_x_r;
    s2_pos_r   <= s1_pos_r;
    s2_pwc_r   <= s1_pwc_r;
    s3_acr_r   <= acr_nxt;
    s3_xa_r    <= s2_x_r - acr_nxt;
    s3_pos_r   <= s2_pos_r;
    s3_pwc_r   <= s2_pwc_r;
    s4_dpos_r  <= s3_xa_r - pw_w;
    s4_dneg_r  <= pw_w - s3_xa_r;
    s4_pred_r  <= pw_w + s3_acr_r;
    s4_pos_r   <= s3_pos_r;
    s5_neg_r   <= neg_nxt;
    s5_sat_r   <= sat_nxt;
    s5_rsum_r  <= rsum_nxt;
    s5_pred_r  <= s4_pred_r;
    s5_pos_r   <= s4_pos_r;
    s6_recon_r <= recon_nxt;
    s6_qabs_r  <= qabs_nxt;
    s6_neg_r   <= s5_neg_r;
    s6_sat_r   <= s5_sat_r;
  end

  // weighted reconstruction for the next word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
    end else if (s6_v_r) begin
      prod_r <= s6_recon_r * coeff_along;
    end
  end

  assign push           = s6_v_r;
  assign push_data.code = s6_neg_r ? (32'd0 - s6_qabs_r) : s6_qabs_r;
  assign push_data.sat  = s6_sat_r;

endmodule

FILE: rtl/pqe_outq.sv
module pqe_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pqe_pkg::result_t  push_data,
  input  logic              pop,
  output logic              out_valid,
  output pqe_pkg::result_t  out_data,
  output pqe_pkg::oq_stat_t stat
);
  import pqe_pkg::*;

  result_t             slot_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + OQ_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - OQ_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // result slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(1);
      end
    end
  end

  assign out_valid  = (cnt_r != '0);
  assign out_data   = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == OQ_CNT_W'(OQ_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

FILE: rtl/predictive_quantizer_encoder_unit.sv
// predictive quantizer encoder: row-major DPCM with along-row and row-above terms
// each accepted word is registered through the datapath stages and the result queue before its result word is presented
// input: a new word is accepted only once the previous one has left the prediction feedback
//   loop (offset, rounding, reconstruction, coefficient multiply), and later when
//   consecutive words use the same line buffer entry (row length of one)
// reset: synchronous, active low; clears registers, position and pipeline, not the line buffer
module predictive_quantizer_encoder_unit #(
  parameter int MAX_ROW = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pqe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pqe_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [31:0]                   in_sample,
  input  logic                                 in_start_req,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [31:0]                   out_code,
  output logic                                 out_saturated
);
  import pqe_pkg::*;

  localparam int POS_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

  logic signed [TPW-1:0] tick_power_r;
  logic [AXW-1:0]        axis_count_r;
  logic [LENW-1:0]       row_length_r;
  logic signed [CW-1:0]  coeff_along_r;
  logic signed [CW-1:0]  coeff_across_r;

  issue_t           issue;
  logic [POS_W-1:0] issue_pos;
  logic             dp_push;
  result_t          dp_data;
  result_t          oq_data;
  oq_stat_t         oq_stat;
  logic             pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_power_r   <= -TPW'(8);
      axis_count_r   <= AXW'(1);
      row_length_r   <= LENW'(1024);
      coeff_along_r  <= '0;
      coeff_across_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TICK_POWER:   tick_power_r   <= cfg_wdata[TPW-1:0];
        REG_AXIS_COUNT:   axis_count_r   <= cfg_wdata[AXW-1:0];
        REG_ROW_LENGTH:   row_length_r   <= cfg_wdata[LENW-1:0];
        REG_COEFF_ALONG:  coeff_along_r  <= cfg_wdata[CW-1:0];
        REG_COEFF_ACROSS: coeff_across_r <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  assign pop = out_valid && out_ready;

  // row sequencing and issue control
  pqe_ctrl #(.MAX_ROW(MAX_ROW)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_start_req (in_start_req),
    .in_ready     (in_ready),
    .axis_count   (axis_count_r),
    .row_length   (row_length_r),
    .coeff_across (coeff_across_r),
    .pop          (pop),
    .issue        (issue),
    .issue_pos    (issue_pos)
  );

  // prediction, quantization and line buffer
  pqe_dpath #(.MAX_ROW(MAX_ROW), .FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .issue        (issue),
    .issue_pos    (issue_pos),
    .in_sample    (in_sample),
    .tick_power   (tick_power_r),
    .coeff_along  (coeff_along_r),
    .coeff_across (coeff_across_r),
    .push         (dp_push),
    .push_data    (dp_data)
  );

  // result buffering
  pqe_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (dp_push),
    .push_data (dp_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (oq_data),
    .stat      (oq_stat)
  );

  assign out_code      = oq_data.code;
  assign out_saturated = oq_data.sat;

  // a result never lands in a full queue
  assert property (@(posedge clk) disable iff (!rst_n) dp_push |-> !oq_stat.full)
    else $error("result pushed into full queue");

  // every accepted word produces its result after the fixed pipeline delay
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##6 dp_push)
    else $error("result missing after accepted word");

  // feedback loop holds one word at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !(in_valid && in_ready) ##1 !(in_valid && in_ready)
                               ##1 !(in_valid && in_ready))
    else $error("word accepted inside the feedback interval");

endmodule

FILE: tb/sv/predictive_quantizer_encoder_unit_tb.sv
`timescale 1ns / 100ps

module predictive_quantizer_encoder_unit_tb;
  import pqe_pkg::*;

  localparam int LINE_DEPTH        = 1024;
  localparam int SAMPLE_FRAC       = 16;
  localparam int WORDS_PER_SETTING = 50;
  localparam int SETTINGS_PER_MODE = 5;

  localparam longint RECON_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint RECON_MIN = 64'shFFFF_8000_0000_0000;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    cfg_reg_t    reg_sel;
    logic [31:0] value;
    logic        start;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic signed [31:0]    in_sample    = '0;
  logic                  in_start_req = 1'b0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic signed [31:0]    out_code;
  logic                  out_saturated;

  predictive_quantizer_encoder_unit #(
    .MAX_ROW(LINE_DEPTH),
    .FRAC_BITS(SAMPLE_FRAC)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample(in_sample),
    .in_start_req(in_start_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_code(out_code),
    .out_saturated(out_saturated)
  );

  // encoder model state
  longint                line_recon [LINE_DEPTH];
  bit                    line_written [LINE_DEPTH];
  longint                along_term;
  int                    col_idx;
  bit                    below_first_row;
  logic signed [TPW-1:0] tick_pow;
  logic [AXW-1:0]        axes_sel;
  logic [LENW-1:0]       row_len;
  logic signed [CW-1:0]  k_along;
  logic signed [CW-1:0]  k_across;

  result_t   pending_results [$];
  result_t   head;
  stim_row_t directed_rows [$];
  int        mismatches = 0;
  int        send_idle  = 12;
  int        recv_idle  = 64;
  int        wave       = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat48(longint v);
    if (v > RECON_MAX) return RECON_MAX;
    if (v < RECON_MIN) return RECON_MIN;
    return v;
  endfunction

  // code one sample and advance the model
  function automatic result_t quantize_word(logic signed [31:0] smp, logic st);
    int lim;
    int pos;
    int sh;
    longint x;
    longint pred;
    longint offset;
    longint recon;
    longint unsigned mag;
    longint unsigned qabs;
    longint unsigned step_mag;
    bit neg;
    bit sat;
    result_t res;
    lim = int'(row_len);
    if (lim == 0) lim = 1;
    if (lim > LINE_DEPTH) lim = LINE_DEPTH;
    sh = PRED_FRAC + int'(tick_pow);
    if (st) begin
      col_idx = 0;
      below_first_row = 1'b0;
      along_term = 0;
    end
    pos = (col_idx >= LINE_DEPTH) ? 0 : col_idx;
    x = longint'(smp) <<< (PRED_FRAC - SAMPLE_FRAC);
    // along-row term plus the row-above term
    pred = along_term;
    if (axes_sel >= 2 && below_first_row && k_across != 0)
      pred += (line_recon[pos] * longint'(k_across)) >>> COEFF_SHIFT;
    // round half away from zero, then pin to int32
    offset = x - pred;
    neg = offset < 0;
    mag = neg ? -offset : offset;
    qabs = (mag + (64'd1 << (sh - 1))) >> sh;
    sat = 1'b0;
    if (neg) begin
      if (qabs > 64'h8000_0000) begin
        qabs = 64'h8000_0000;
        sat = 1'b1;
      end
    end else if (qabs > 64'h7FFF_FFFF) begin
      qabs = 64'h7FFF_FFFF;
      sat = 1'b1;
    end
    // reconstruction feeds the line buffer and the next prediction
    step_mag = qabs << sh;
    recon = neg ? pred - $signed(step_mag) : pred + $signed(step_mag);
    recon = sat48(recon);
    line_recon[pos] = recon;
    line_written[pos] = 1'b1;
    along_term = sat48((recon * longint'(k_along)) >>> COEFF_SHIFT);
    col_idx = pos + 1;
    if (col_idx >= lim) begin
      col_idx = 0;
      below_first_row = 1'b1;
      if (axes_sel >= 2) along_term = 0;
    end
    res.code = neg ? (~qabs[31:0] + 32'd1) : qabs[31:0];
    res.sat = sat;
    return res;
  endfunction

  function automatic void add_word(logic [31:0] s, logic st);
    stim_row_t r;
    r.kind = ROW_WORD;
    r.reg_sel = REG_TICK_POWER;
    r.value = s;
    r.start = st;
    r.typed = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_checked(logic [31:0] s, logic st, logic [31:0] code, logic sat);
    stim_row_t r;
    r.kind = ROW_WORD;
    r.reg_sel = REG_TICK_POWER;
    r.value = s;
    r.start = st;
    r.typed = 1'b1;
    r.want.code = code;
    r.want.sat = sat;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(cfg_reg_t sel, logic [31:0] v);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.reg_sel = sel;
    r.value = v;
    r.start = 1'b0;
    r.typed = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic logic [CW-1:0] pick_coeff();
    int v;
    case ($urandom_range(7))
      0: v = -256;
      1: v = 256;
      2: v = 0;
      3: v = $urandom;
      default: v = int'($urandom_range(512)) - 256;
    endcase
    return v[CW-1:0];
  endfunction

  // mostly a smooth signal, with noise, tiny values and rail values mixed in
  function automatic logic [31:0] next_sample();
    logic [31:0] s;
    case ($urandom_range(9))
      0: s = $urandom;
      1: s = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: s = int'($urandom_range(255)) - 128;
      default: begin
        wave = wave + ((int'($urandom_range(4095)) - 2048) <<< $urandom_range(12));
        s = wave;
      end
    endcase
    return s;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    case (sel)
      REG_TICK_POWER:   tick_pow = val[TPW-1:0];
      REG_AXIS_COUNT:   axes_sel = val[AXW-1:0];
      REG_ROW_LENGTH:   row_len = val[LENW-1:0];
      REG_COEFF_ALONG:  k_along = val[CW-1:0];
      REG_COEFF_ACROSS: k_across = val[CW-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(logic [31:0] smp, logic st, bit typed, result_t want);
    int gap;
    int pos;
    result_t got;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // a line entry never written must not be read: restart the array instead
    pos = (col_idx >= LINE_DEPTH) ? 0 : col_idx;
    if (axes_sel >= 2 && below_first_row && k_across != 0 && !line_written[pos]) st = 1'b1;
    got = quantize_word(smp, st);
    pending_results.push_back(typed ? want : got);
    in_valid <= 1'b1;
    in_sample <= smp;
    in_start_req <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pick_setting();
    logic [TPW-1:0] tp;
    logic [LENW-1:0] len;
    int r;
    case ($urandom_range(3))
      0: tp = 5'h10;  // finest step
      1: tp = 5'h0F;  // coarsest step
      default: tp = $urandom_range(31);
    endcase
    r = $urandom_range(19);
    if (r == 0) len = '0;
    else if (r == 1) len = 11'd1024;
    else if (r == 2) len = $urandom_range(2047, 1025);
    else if (r < 8) len = 11'd1;
    else len = $urandom_range(12, 2);
    write_reg(REG_TICK_POWER, {{(CFG_DATA_W-TPW){1'b0}}, tp});
    write_reg(REG_AXIS_COUNT, $urandom_range(3));
    write_reg(REG_ROW_LENGTH, len);
    write_reg(REG_COEFF_ALONG, {{(CFG_DATA_W-CW){1'b0}}, pick_coeff()});
    write_reg(REG_COEFF_ACROSS, {{(CFG_DATA_W-CW){1'b0}}, pick_coeff()});
  endtask

  // result side: random back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: code %0d saturated %0d", out_code, out_saturated);
        mismatches++;
      end else begin
        head = pending_results.pop_front();
        if (out_code !== head.code) begin
          $error("code: expected %0d, actual %0d", $signed(head.code), out_code);
          mismatches++;
        end
        if (out_saturated !== head.sat) begin
          $error("saturated: expected %0d, actual %0d", head.sat, out_saturated);
          mismatches++;
        end
      end
    end
  end

  // main sequence
  initial begin
    logic st;
    foreach (line_recon[i]) begin
      line_recon[i] = 0;
      line_written[i] = 1'b0;
    end
    along_term = 0;
    col_idx = 0;
    below_first_row = 1'b0;
    tick_pow = 5'h18;
    axes_sel = 2'd1;
    row_len = 11'd1024;
    k_along = '0;
    k_across = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: step of 2^-8, no prediction
    add_checked(32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0);
    add_checked(32'h0000_0100, 1'b0, 32'h0000_0001, 1'b0);
    add_checked(32'h0000_0080, 1'b0, 32'h0000_0001, 1'b0);
    add_checked(32'hFFFF_FF80, 1'b0, 32'hFFFF_FFFF, 1'b0);
    add_checked(32'h0000_007F, 1'b0, 32'h0000_0000, 1'b0);
    add_checked(32'h7FFF_FFFF, 1'b0, 32'h0080_0000, 1'b0);
    add_checked(32'h8000_0000, 1'b0, 32'hFF80_0000, 1'b0);
    // finest step, full along-row weight: saturation both ways, exact negative limit
    add_cfg(REG_TICK_POWER, 32'h10);
    add_cfg(REG_COEFF_ALONG, 32'h100);
    add_checked(32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0);
    add_checked(32'h8000_0000, 1'b0, 32'h8000_0000, 1'b1);
    add_word(32'h8000_0000, 1'b0);
    add_word(32'h7FFF_FFFF, 1'b0);
    add_checked(32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0);
    // coarsest step, two axes, row length zero acts as one
    add_cfg(REG_TICK_POWER, 32'h0F);
    add_cfg(REG_AXIS_COUNT, 32'd2);
    add_cfg(REG_ROW_LENGTH, 32'd0);
    add_cfg(REG_COEFF_ALONG, 32'h300);
    add_cfg(REG_COEFF_ACROSS, 32'h100);
    add_word(32'h7FFF_FFFF, 1'b1);
    add_word(32'h8000_0000, 1'b0);
    add_word(32'h1234_5678, 1'b0);
    add_word(32'h0000_0000, 1'b0);
    // unit step, short rows with both terms negative
    add_cfg(REG_TICK_POWER, 32'd0);
    add_cfg(REG_AXIS_COUNT, 32'd3);
    add_cfg(REG_ROW_LENGTH, 32'd3);
    add_cfg(REG_COEFF_ACROSS, 32'h300);
    add_word(32'h0001_0000, 1'b1);
    add_word(32'h0002_8000, 1'b0);
    add_word(32'hFFFF_0000, 1'b0);
    add_word(32'h7FFF_0000, 1'b0);
    add_word(32'h8001_0000, 1'b0);
    // row shortened in the middle of a row, one axis
    add_cfg(REG_ROW_LENGTH, 32'd2);
    add_cfg(REG_AXIS_COUNT, 32'd0);
    add_word(32'h0000_4000, 1'b0);
    add_word(32'hFFFF_C000, 1'b0);
    // row length above the buffer depth
    add_cfg(REG_ROW_LENGTH, 32'h7FF);
    add_cfg(REG_AXIS_COUNT, 32'd2);
    add_word(32'h0300_0000, 1'b0);
    add_word(32'hFD00_0000, 1'b0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].reg_sel, directed_rows[i].value[CFG_DATA_W-1:0]);
      else
        send_word(directed_rows[i].value, directed_rows[i].start,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // random arrays under three idling patterns
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle = 12; recv_idle = 64; end
        1: begin send_idle = 64; recv_idle = 12; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int k = 0; k < SETTINGS_PER_MODE; k++) begin
        pick_setting();
        for (int n = 0; n < WORDS_PER_SETTING; n++) begin
          st = (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(31) == 0);
          send_word(next_sample(), st, 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: predictive_quantizer_encoder_unit.f
rtl/pqe_pkg.sv
rtl/pqe_ctrl.sv
rtl/pqe_dpath.sv
rtl/pqe_outq.sv
rtl/predictive_quantizer_encoder_unit.sv
tb/sv/predictive_quantizer_encoder_unit_tb.sv
